// ----- src/mf_pkg.sv -----
package mf_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int COORD_W    = 10;
  localparam int SIZE_W     = 11;
  localparam int PIX_W      = 8;
  localparam int WIN        = 4;
  localparam int HIST       = 3;
  localparam int NVAL       = WIN * WIN;
  localparam int PICK       = 8;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // One full window on its way from the front end to the rank pipeline.
  typedef struct packed {
    logic [COORD_W-1:0]         x;
    logic [COORD_W-1:0]         y;
    logic                       last;
    logic [NVAL-1:0][PIX_W-1:0] vals;
  } win_item_t;

  // Limits a frame dimension to 1..maxv.
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// ----- src/mf_front.sv -----
module mf_front import mf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              frame_start,
  input  logic [SIZE_W-1:0] width,
  input  logic [SIZE_W-1:0] height,
  input  logic [QCNT_W-1:0] q_count,
  output logic              full,
  output logic              q_push,
  output win_item_t         q_item
);

  logic [COORD_W-1:0] col_r, row_r;
  logic [COORD_W-1:0] cx, cy;
  logic [SIZE_W-1:0]  cx_inc, cy_inc;
  logic               accept, emit0, last0;

  logic               v1_r, emit1_r, last1_r, byp_r;
  logic [ADDR_W-1:0]  cx1_r;
  logic [COORD_W-1:0] x1_r, y1_r;
  logic [PIX_W-1:0]   p1_r;
  logic [3*PIX_W-1:0] bypd_r, ls_q_r, rd, wr_data;

  logic [3*PIX_W-1:0] ls_mem [MAX_WIDTH];
  logic [WIN-1:0][HIST-1:0][PIX_W-1:0] win_r;
  logic [WIN-1:0][PIX_W-1:0] col;

  // Back-pressure counts the item in flight toward the queue.
  assign full   = ({1'b0, q_count} + {{QCNT_W{1'b0}}, v1_r}) >= (QCNT_W+1)'(QDEPTH);
  assign accept = push && !full;

  assign cx     = frame_start ? '0 : col_r;
  assign cy     = frame_start ? '0 : row_r;
  assign cx_inc = {1'b0, cx} + SIZE_W'(1);
  assign cy_inc = {1'b0, cy} + SIZE_W'(1);
  assign emit0  = (cx >= COORD_W'(4)) && (cy >= COORD_W'(4)) &&
                  ({1'b0, cx} < width) && ({1'b0, cy} < height);
  assign last0  = ({1'b0, cx} == width - SIZE_W'(1)) &&
                  ({1'b0, cy} == height - SIZE_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
    end else begin
      v1_r <= accept;
      if (accept) begin
        if (cx_inc >= width) begin
          col_r <= '0;
          row_r <= (cy_inc >= height) ? '0 : cy_inc[COORD_W-1:0];
        end else begin
          col_r <= cx_inc[COORD_W-1:0];
          row_r <= cy;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx1_r   <= cx[ADDR_W-1:0];
      x1_r    <= cx - COORD_W'(2);
      y1_r    <= cy - COORD_W'(2);
      emit1_r <= emit0;
      last1_r <= last0;
      p1_r    <= pixel;
      // The column being written this cycle is the one being read.
      byp_r   <= v1_r && (cx1_r == cx[ADDR_W-1:0]);
      bypd_r  <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) ls_q_r <= ls_mem[cx[ADDR_W-1:0]];
    if (v1_r) ls_mem[cx1_r] <= wr_data;
  end

  assign rd      = byp_r ? bypd_r : ls_q_r;
  assign col[0]  = rd[PIX_W-1:0];
  assign col[1]  = rd[2*PIX_W-1:PIX_W];
  assign col[2]  = rd[3*PIX_W-1:2*PIX_W];
  assign col[3]  = p1_r;
  assign wr_data = {p1_r, col[2], col[1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (v1_r) begin
      for (int r = 0; r < WIN; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
        win_r[r][2] <= col[r];
      end
    end
  end

  always_comb begin
    q_item.x    = x1_r;
    q_item.y    = y1_r;
    q_item.last = last1_r;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < HIST; c++) q_item.vals[r*WIN+c] = win_r[r][c];
      q_item.vals[r*WIN+HIST] = col[r];
    end
  end

  assign q_push = v1_r && emit1_r;

endmodule

// ----- src/mf_queue.sv -----
module mf_queue import mf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  win_item_t         wr_item,
  input  logic              rd,
  output win_item_t         head,
  output logic              empty,
  output logic [QCNT_W-1:0] count
);

  win_item_t          q_mem [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, rp_r;
  logic [QCNT_W-1:0]  cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + QPTR_W'(1);
      if (rd) rp_r <= rp_r + QPTR_W'(1);
      cnt_r <= cnt_r + {{(QCNT_W-1){1'b0}}, wr} - {{(QCNT_W-1){1'b0}}, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_mem[wp_r] <= wr_item;
  end

  assign head  = q_mem[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;

endmodule

// ----- src/mf_back.sv -----
module mf_back import mf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  win_item_t          q_head,
  output logic               q_pop,
  input  logic               pop,
  output logic               empty,
  output logic [COORD_W-1:0] x,
  output logic [COORD_W-1:0] y,
  output logic [PIX_W-1:0]   median,
  output logic               last
);

  logic      en;
  logic      va_r, vb_r, vc_r;
  win_item_t a_r, b_r;
  logic [NVAL-1:0][NVAL-1:0] beat_a, beat_r;
  logic [NVAL-1:0] hot, hot_r;
  logic [PIX_W-1:0] sel;

  assign en    = !vc_r || pop;
  assign q_pop = en && !q_empty;

  // Value i outranks value j when j is smaller, or equal and earlier.
  always_comb begin
    for (int i = 0; i < NVAL; i++) begin
      for (int j = 0; j < NVAL; j++) begin
        beat_a[i][j] = (j != i) && ((q_head.vals[j] < q_head.vals[i]) ||
                       ((q_head.vals[j] == q_head.vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NVAL; i++) begin
      hot[i] = ($countones(beat_r[i]) == PICK);
    end
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < NVAL; i++) begin
      if (hot_r[i]) sel = sel | b_r.vals[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= !q_empty;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= q_head;
      beat_r <= beat_a;
      b_r    <= a_r;
      hot_r  <= hot;
      x      <= b_r.x;
      y      <= b_r.y;
      last   <= b_r.last;
      median <= sel;
    end
  end

  assign empty = !vc_r;

endmodule

// ----- src/median_filter_4x4.sv -----
// Streaming 4x4 upper-median filter for 8-bit gray pixels in raster order.
// Write the frame size first (register 0 is the width, register 1 the height,
// reset 640 by 480; values are clamped to 1..1024). Push one pixel per request
// and raise in_frame_start on the first pixel of every frame; a frame that
// runs past its last pixel simply wraps to a new one. For every interior
// position (x,y) with 2 <= x <= width-3 and 2 <= y <= height-3 the block
// returns the ninth smallest of the 16 pixels in columns x-1..x+2 and rows
// y-1..y+2, tagged with x and y; out_frame_last marks the final interior pixel.
// Border pixels are not produced and the consumer fills them in as 255, so
// frames under five pixels in either direction give no results. A result
// becomes available once pixel (x+2,y+2) has been pushed and its window has
// passed the front-end register, the queue and the rank pipeline.
// The block takes one pixel every clock cycle as long as results are popped;
// that rate is set by the single read and single write per cycle on the
// line-store memory, which holds three previous rows per column. The front
// end keeps the position counters, the line store and the window registers
// and hands complete windows through a four-entry queue to a three-stage rank
// pipeline (compare, count, select) whose last stage is the result register.
// The line store needs no clearing after reset: only written entries are
// ever used for a result.
module median_filter_4x4 import mf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_frame_start,
  output logic               empty,
  input  logic               pop,
  output logic [COORD_W-1:0] out_out_x,
  output logic [COORD_W-1:0] out_out_y,
  output logic [PIX_W-1:0]   out_median_value,
  output logic               out_frame_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data
);

  logic [SIZE_W-1:0] width_r, height_r, width_eff, height_eff;
  logic              q_wr, q_rd, q_empty;
  win_item_t         q_in, q_head;
  logic [QCNT_W-1:0] q_count;

  // Frame size registers; only written while the block is idle (a rule for the user; not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(640);
      height_r <= SIZE_W'(480);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_eff  = clamp_size(width_r, SIZE_W'(MAX_WIDTH));
  assign height_eff = clamp_size(height_r, SIZE_W'(MAX_HEIGHT));

  mf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pixel       (in_pixel),
    .frame_start (in_frame_start),
    .width       (width_eff),
    .height      (height_eff),
    .q_count     (q_count),
    .full        (full),
    .q_push      (q_wr),
    .q_item      (q_in)
  );

  mf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (q_in),
    .rd      (q_rd),
    .head    (q_head),
    .empty   (q_empty),
    .count   (q_count)
  );

  mf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_rd),
    .pop     (pop),
    .empty   (empty),
    .x       (out_out_x),
    .y       (out_out_y),
    .median  (out_median_value),
    .last    (out_frame_last)
  );

endmodule

// ----- src/mf_checker.sv -----
module mf_checker import mf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               push,
  input logic               full,
  input logic [PIX_W-1:0]   in_pixel,
  input logic               in_frame_start,
  input logic               empty,
  input logic               pop,
  input logic [COORD_W-1:0] out_out_x,
  input logic [COORD_W-1:0] out_out_y,
  input logic [PIX_W-1:0]   out_median_value,
  input logic               out_frame_last,
  input logic               cfg_we,
  input logic               cfg_index,
  input logic [SIZE_W-1:0]  cfg_data
);

  // Nothing is waiting right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // A result that is not taken stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_out_x) && $stable(out_out_y) &&
                          $stable(out_median_value) && $stable(out_frame_last)))
    else $error("waiting result changed");

  // Only positions clear of the left and top border are ever produced.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_out_x >= COORD_W'(2) && out_out_y >= COORD_W'(2)))
    else $error("border position produced");

  // No result is waiting as reset is released.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> empty)
    else $error("result without a pixel");

endmodule

bind median_filter_4x4 mf_checker u_mf_checker (.*);

// ----- sim/median_checker.sv -----
`timescale 1ns / 100ps

module median_checker import mf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               full,
  input  logic [PIX_W-1:0]   in_pixel,
  input  logic               in_frame_start,
  input  logic               empty,
  input  logic               pop,
  input  logic [COORD_W-1:0] out_out_x,
  input  logic [COORD_W-1:0] out_out_y,
  input  logic [PIX_W-1:0]   out_median_value,
  input  logic               out_frame_last,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [SIZE_W-1:0]  cfg_data,
  output int                 errors,
  output int                 pending
);

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   med;
    logic               last;
  } median_t;

  median_t           median_q[$];
  logic [PIX_W-1:0]  rows_mem[HIST][MAX_WIDTH];
  logic [PIX_W-1:0]  cols_reg[WIN][HIST];
  int unsigned       col_pos, row_pos;
  logic [SIZE_W-1:0] size_w, size_h;

  initial begin
    errors  = 0;
    pending = 0;
    foreach (rows_mem[i, j]) rows_mem[i][j] = '0;
  end

  task automatic report(input string what);
    errors++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  function automatic int unsigned limit(input logic [SIZE_W-1:0] v, input int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rank9(input logic [PIX_W-1:0] v[NVAL]);
    logic [PIX_W-1:0] a[NVAL];
    logic [PIX_W-1:0] t;
    a = v;
    for (int i = 1; i < NVAL; i++) begin
      for (int j = i; j > 0 && a[j-1] > a[j]; j--) begin
        t = a[j]; a[j] = a[j-1]; a[j-1] = t;
      end
    end
    return a[PICK];
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] p, input logic fs);
    logic [PIX_W-1:0] column[WIN];
    logic [PIX_W-1:0] window[NVAL];
    int unsigned      w, h, cx, cy;
    median_t          m;
    w = limit(size_w, MAX_WIDTH);
    h = limit(size_h, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    cx = col_pos;
    cy = row_pos;
    column[0] = rows_mem[0][cx];
    column[1] = rows_mem[1][cx];
    column[2] = rows_mem[2][cx];
    column[3] = p;
    rows_mem[0][cx] = column[1];
    rows_mem[1][cx] = column[2];
    rows_mem[2][cx] = p;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < HIST; c++) window[r*WIN+c] = cols_reg[r][c];
      window[r*WIN+HIST] = column[r];
    end
    if (cx >= 4 && cy >= 4 && cx < w && cy < h) begin
      m.x    = COORD_W'(cx - 2);
      m.y    = COORD_W'(cy - 2);
      m.med  = rank9(window);
      m.last = (cx == w - 1) && (cy == h - 1);
      median_q.push_back(m);
    end
    for (int r = 0; r < WIN; r++) begin
      cols_reg[r][0] = cols_reg[r][1];
      cols_reg[r][1] = cols_reg[r][2];
      cols_reg[r][2] = column[r];
    end
    if (cx + 1 >= w) begin
      col_pos = 0;
      row_pos = (cy + 1 >= h) ? 0 : cy + 1;
    end else begin
      col_pos = cx + 1;
    end
  endtask

  always @(posedge clk) begin
    median_t m;
    if (!rst_n) begin
      size_w  = SIZE_W'(640);
      size_h  = SIZE_W'(480);
      col_pos = 0;
      row_pos = 0;
      foreach (cols_reg[r, c]) cols_reg[r][c] = '0;
      median_q.delete();
    end else begin
      if (pop && !empty) begin
        if (median_q.size() == 0) begin
          report($sformatf("unexpected result x=%0d y=%0d", out_out_x, out_out_y));
        end else begin
          m = median_q.pop_front();
          if (out_out_x !== m.x)
            report($sformatf("out_x %0d, expected %0d", out_out_x, m.x));
          if (out_out_y !== m.y)
            report($sformatf("out_y %0d, expected %0d", out_out_y, m.y));
          if (out_median_value !== m.med)
            report($sformatf("median at (%0d,%0d) is %0d, expected %0d",
                             m.x, m.y, out_median_value, m.med));
          if (out_frame_last !== m.last)
            report($sformatf("frame_last at (%0d,%0d) is %b", m.x, m.y, out_frame_last));
        end
      end
      if (push && !full) predict_pixel(in_pixel, in_frame_start);
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) size_w = cfg_data;
        else size_h = cfg_data;
      end
    end
    pending = median_q.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb import mf_pkg::*;;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [PIX_W-1:0]   in_pixel = '0;
  logic               in_frame_start = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [COORD_W-1:0] out_out_x;
  logic [COORD_W-1:0] out_out_y;
  logic [PIX_W-1:0]   out_median_value;
  logic               out_frame_last;
  logic               cfg_we = 1'b0;
  logic               cfg_index = REG_WIDTH;
  logic [SIZE_W-1:0]  cfg_data = '0;
  int                 errors;
  int                 pending;

  // When quiet is set neither side idles; hold_req asks the receiver for one
  // long hold-off so that the internal queue fills and full is raised.
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int pixels_sent = 0;

  always #2 clk = ~clk;

  median_filter_4x4 u_dut (
    .clk, .rst_n, .push, .full, .in_pixel, .in_frame_start,
    .empty, .pop, .out_out_x, .out_out_y, .out_median_value, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_data
  );

  median_checker u_check (
    .clk, .rst_n, .push, .full, .in_pixel, .in_frame_start,
    .empty, .pop, .out_out_x, .out_out_y, .out_median_value, .out_frame_last,
    .cfg_we, .cfg_index, .cfg_data, .errors, .pending
  );

  // Receiver: pops most of the time, with random bursts of idle cycles and
  // one long counted hold-off on request.
  initial begin
    int gap;
    int hold;
    gap = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold == 0) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 11) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offers one pixel request and holds it until the block takes it. The
  // full flag only changes at rising edges, so it is sampled at the falling one.
  task automatic push_pixel(input logic [PIX_W-1:0] p, input logic fs);
    bit taken;
    in_pixel <= p;
    in_frame_start <= fs;
    push <= 1'b1;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    pixels_sent++;
    if (!quiet && $urandom_range(0, 15) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Stops the sender until every predicted result has been popped, then
  // lets the rank pipeline drain past any window that produced nothing.
  task automatic drain;
    push <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int eff_size(input logic [SIZE_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_WIDTH) return MAX_WIDTH;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Sends n pixels of a frame. The style picks the contents: 0 random,
  // 1 all black, 2 all white, 3 pixels alternating between the two extremes.
  // Noisy frames get stray frame-start flags.
  task automatic send_frame(input int n, input int style, input bit noisy);
    logic [PIX_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      case (style)
        1:       p = '0;
        2:       p = '1;
        3:       p = i[0] ? '1 : '0;
        default: p = rand_pixel();
      endcase
      push_pixel(p, (i == 0) || (noisy && $urandom_range(0, 40) == 0));
    end
  endtask

  function automatic logic [SIZE_W-1:0] rand_dim();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return SIZE_W'($urandom_range(1, 4));
      2, 3:    return SIZE_W'($urandom_range(13, 30));
      default: return SIZE_W'($urandom_range(5, 12));
    endcase
  endfunction

  initial begin
    logic [SIZE_W-1:0] w, h;
    int n;
    int k;
    bit noisy;
    bit held;
    held = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the smallest frame with a result, flat black and white
    // frames, extremes side by side, clamping of zero sizes and a frame just
    // too narrow to produce anything.
    set_size(SIZE_W'(5), SIZE_W'(5));
    send_frame(25, 1, 1'b0);
    send_frame(25, 2, 1'b0);
    set_size(SIZE_W'(6), SIZE_W'(5));
    send_frame(30, 3, 1'b0);
    set_size(SIZE_W'(0), SIZE_W'(0));
    send_frame(3, 0, 1'b0);
    w = SIZE_W'(4);
    h = SIZE_W'(6);
    set_size(w, h);
    send_frame(24, 0, 1'b0);

    // Random frames of mostly small sizes. Some are cut short, some run past
    // their end without a new frame start, and some carry stray frame starts.
    // Once, a full frame is sent while the receiver holds off for long.
    while (pixels_sent < 900 || !held) begin
      if ($urandom_range(0, 2) == 0) begin
        w = rand_dim();
        h = rand_dim();
        set_size(w, h);
      end
      if (!held && pixels_sent > 450) begin
        held = 1'b1;
        w = SIZE_W'(12);
        h = SIZE_W'(12);
        set_size(w, h);
        hold_req = 1'b1;
        send_frame(144, 0, 1'b0);
      end
      if ($urandom_range(0, 7) == 0) drain();
      n = eff_size(w) * eff_size(h);
      noisy = 1'b0;
      case ($urandom_range(0, 9))
        0:       k = $urandom_range(1, n);
        1:       k = n + $urandom_range(1, 3 * n);
        2: begin
          k = n;
          noisy = 1'b1;
        end
        default: k = n;
      endcase
      if (k > 900 - pixels_sent) k = 900 - pixels_sent;
      if (k > 0) send_frame(k, 0, noisy);
    end

    // Width register above its limit on a short run, then a narrow strip
    // with the height register above its limit.
    set_size(SIZE_W'(2047), SIZE_W'(5));
    send_frame(100, 0, 1'b0);
    set_size(SIZE_W'(5), SIZE_W'(2047));
    send_frame(5 * 20, 0, 1'b0);

    // Last part runs at full rate on both sides.
    set_size(SIZE_W'(9), SIZE_W'(7));
    quiet = 1'b1;
    send_frame(63, 0, 1'b0);
    send_frame(63, 0, 1'b0);

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
